>>> sv/u8sv_pkg.sv
// Shared types and constants for the UTF-8 stream validator.
// Used by u8sv_front, u8sv_fifo, u8sv_back and utf8_stream_validator.
package u8sv_pkg;

  // Class of a raw byte, set by the front end
  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_INVALID
  } byte_class_e;

  // Error codes as reported on error_kind
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_LEAD  = 3'd1,
    ERR_BAD_CONT  = 3'd2,
    ERR_TRUNCATED = 3'd3,
    ERR_OVERLONG  = 3'd4,
    ERR_SURROGATE = 3'd5,
    ERR_RANGE     = 3'd6
  } err_kind_e;

  // One classified byte as queued between front and back
  typedef struct packed {
    byte_class_e cls;
    logic [6:0]  bits;   // payload bits with the marker bits stripped
    logic        last;
  } byte_item_t;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] MIN_W2   = 21'h00080;
  localparam logic [CP_W-1:0] MIN_W3   = 21'h00800;
  localparam logic [CP_W-1:0] MIN_W4   = 21'h10000;
  localparam logic [CP_W-1:0] SURR_LO  = 21'h0D800;
  localparam logic [CP_W-1:0] SURR_HI  = 21'h0DFFF;
  localparam logic [CP_W-1:0] MAX_CP   = 21'h10FFFF;

  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;

  // Queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

endpackage

>>> sv/utf8_stream_validator.sv
// UTF-8 stream validator, top level.
// Instantiates u8sv_front, u8sv_fifo and u8sv_back; types from u8sv_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one byte of a buffer per
//   beat, with last_byte_i set on the final byte. Output channel
//   (out_valid_o / out_ready_i) gives exactly one result beat per input beat,
//   in order: a completed code point with its width, the buffer verdict on the
//   last byte, and the first error kind seen so far in the buffer.
//   Path: an accepted byte is written into the queue, then the back end pops
//   it and loads its result into the output register.
//   Throughput: one byte per cycle, sustained while out_ready_i stays high.
//   The front end classifies the byte into a two-entry queue; the back end
//   updates the sequence state and loads the output register for each byte.
//   Receiver stall: the output register holds its beat, the back end stops
//   popping, the queue takes at most two more bytes and then in_ready_o drops.
//   Reset: clears the queue, the sequence state and the output valid. The
//   state also clears after the last byte of each buffer.
module utf8_stream_validator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        point_valid_o,
  output logic [20:0] code_point_o,
  output logic [2:0]  point_width_o,
  output logic        buffer_end_o,
  output logic        buffer_ok_o,
  output logic [2:0]  error_kind_o
);

  logic                 fifo_full;
  logic                 fifo_valid;
  logic                 push;
  logic                 pop;
  u8sv_pkg::byte_item_t front_item;
  u8sv_pkg::byte_item_t head_item;

  u8sv_front u_front (
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .fifo_full_i (fifo_full),
    .in_ready_o  (in_ready_o),
    .push_o      (push),
    .item_o      (front_item)
  );

  u8sv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .item_o  (head_item)
  );

  u8sv_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (fifo_valid),
    .item_i        (head_item),
    .pop_o         (pop),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .point_valid_o (point_valid_o),
    .code_point_o  (code_point_o),
    .point_width_o (point_width_o),
    .buffer_end_o  (buffer_end_o),
    .buffer_ok_o   (buffer_ok_o),
    .error_kind_o  (error_kind_o)
  );

  // A reported code point never comes with an error recorded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && point_valid_o |-> error_kind_o == u8sv_pkg::ERR_NONE)
    else $error("code point reported after an error");

  // A passing verdict only on the last byte and with no error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && buffer_ok_o |-> buffer_end_o && error_kind_o == u8sv_pkg::ERR_NONE)
    else $error("buffer_ok without clean buffer end");

  // Reported points are in range and carry a width of one to four
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && point_valid_o |->
      code_point_o <= u8sv_pkg::MAX_CP && point_width_o != 3'd0 && point_width_o <= 3'd4)
    else $error("bad code point or width");

  // A stalled result beat is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(code_point_o) &&
      $stable(error_kind_o) && $stable(buffer_end_o))
    else $error("output beat changed while stalled");

endmodule

>>> sv/u8sv_front.sv
// Front end of the UTF-8 validator: takes input beats and classifies each byte.
// Depends on u8sv_pkg; pushes classified items into u8sv_fifo.
module u8sv_front (
  input  logic                 in_valid_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  input  logic                 fifo_full_i,
  output logic                 in_ready_o,
  output logic                 push_o,
  output u8sv_pkg::byte_item_t item_o
);

  assign in_ready_o = ~fifo_full_i;
  assign push_o     = in_valid_i & ~fifo_full_i;

  // Byte classification and marker stripping
  always_comb begin
    item_o.last = last_byte_i;
    item_o.bits = data_byte_i[6:0];
    if (!data_byte_i[7]) begin
      item_o.cls = u8sv_pkg::CLS_ASCII;
    end else if (data_byte_i[6] == 1'b0) begin
      item_o.cls  = u8sv_pkg::CLS_CONT;
      item_o.bits = {1'b0, data_byte_i[5:0]};
    end else if (data_byte_i >= u8sv_pkg::LEAD2_LO && data_byte_i <= u8sv_pkg::LEAD2_HI) begin
      item_o.cls  = u8sv_pkg::CLS_LEAD2;
      item_o.bits = {2'b00, data_byte_i[4:0]};
    end else if (data_byte_i >= u8sv_pkg::LEAD3_LO && data_byte_i <= u8sv_pkg::LEAD3_HI) begin
      item_o.cls  = u8sv_pkg::CLS_LEAD3;
      item_o.bits = {3'b000, data_byte_i[3:0]};
    end else if (data_byte_i >= u8sv_pkg::LEAD4_LO && data_byte_i <= u8sv_pkg::LEAD4_HI) begin
      item_o.cls  = u8sv_pkg::CLS_LEAD4;
      item_o.bits = {4'b0000, data_byte_i[2:0]};
    end else begin
      // C0, C1 and F5-FF never start a sequence
      item_o.cls = u8sv_pkg::CLS_INVALID;
    end
  end

endmodule

>>> sv/u8sv_fifo.sv
// Short queue of classified bytes between the front and back ends.
// Depends on u8sv_pkg for the item type and depth.
module u8sv_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  u8sv_pkg::byte_item_t item_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 valid_o,
  output u8sv_pkg::byte_item_t item_o
);

  u8sv_pkg::byte_item_t mem_q [u8sv_pkg::FIFO_DEPTH];

  logic [u8sv_pkg::FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [u8sv_pkg::FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [u8sv_pkg::FIFO_CNT_W-1:0] count_q, count_d;

  localparam logic [u8sv_pkg::FIFO_PTR_W-1:0] LastPtr =
    u8sv_pkg::FIFO_PTR_W'(u8sv_pkg::FIFO_DEPTH - 1);
  localparam logic [u8sv_pkg::FIFO_CNT_W-1:0] FullCnt =
    u8sv_pkg::FIFO_CNT_W'(u8sv_pkg::FIFO_DEPTH);

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> sv/u8sv_back.sv
// Back end of the UTF-8 validator: sequence state, value checks, output register.
// Depends on u8sv_pkg; pops classified items from u8sv_fifo.
module u8sv_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  u8sv_pkg::byte_item_t item_i,
  output logic                 pop_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic                 point_valid_o,
  output logic [20:0]          code_point_o,
  output logic [2:0]           point_width_o,
  output logic                 buffer_end_o,
  output logic                 buffer_ok_o,
  output logic [2:0]           error_kind_o
);

  // Sequence state
  logic [1:0]                    bytes_left_q, bytes_left_d;
  logic [2:0]                    seq_width_q, seq_width_d;
  logic [u8sv_pkg::CP_W-1:0]     partial_q, partial_d;
  logic                          err_seen_q, err_seen_d;
  u8sv_pkg::err_kind_e           first_err_q, first_err_d;

  // Output register
  logic                          out_valid_q;
  logic                          pv_q;
  logic [u8sv_pkg::CP_W-1:0]     cp_q;
  logic [2:0]                    pw_q;
  logic                          end_q;
  logic                          ok_q;
  u8sv_pkg::err_kind_e           kind_q;

  logic                          pv;
  logic [u8sv_pkg::CP_W-1:0]     cp;
  logic [2:0]                    pw;
  logic                          ok;
  u8sv_pkg::err_kind_e           err;
  logic [u8sv_pkg::CP_W-1:0]     acc;
  logic [1:0]                    bl_dec;
  logic                          fire;

  assign fire  = item_valid_i & (~out_valid_q | out_ready_i);
  assign pop_o = fire;

  assign acc    = {partial_q[u8sv_pkg::CP_W-7:0], item_i.bits[5:0]};
  assign bl_dec = bytes_left_q - 2'd1;

  // Decode step for the item at the head of the queue
  always_comb begin
    bytes_left_d = bytes_left_q;
    seq_width_d  = seq_width_q;
    partial_d    = partial_q;
    err_seen_d   = err_seen_q;
    first_err_d  = first_err_q;
    err          = u8sv_pkg::ERR_NONE;
    pv           = 1'b0;
    cp           = '0;
    pw           = 3'd0;

    if (!err_seen_q) begin
      if (bytes_left_q == 2'd0) begin
        // Expecting a lead byte
        case (item_i.cls)
          u8sv_pkg::CLS_ASCII: begin
            pv = 1'b1;
            cp = u8sv_pkg::CP_W'(item_i.bits);
            pw = 3'd1;
          end
          u8sv_pkg::CLS_LEAD2: begin
            seq_width_d  = 3'd2;
            bytes_left_d = 2'd1;
            partial_d    = u8sv_pkg::CP_W'(item_i.bits[4:0]);
          end
          u8sv_pkg::CLS_LEAD3: begin
            seq_width_d  = 3'd3;
            bytes_left_d = 2'd2;
            partial_d    = u8sv_pkg::CP_W'(item_i.bits[3:0]);
          end
          u8sv_pkg::CLS_LEAD4: begin
            seq_width_d  = 3'd4;
            bytes_left_d = 2'd3;
            partial_d    = u8sv_pkg::CP_W'(item_i.bits[2:0]);
          end
          default: err = u8sv_pkg::ERR_BAD_LEAD;
        endcase
      end else if (item_i.cls == u8sv_pkg::CLS_CONT) begin
        // Gather six more bits
        partial_d    = acc;
        bytes_left_d = bl_dec;
        if (bl_dec == 2'd0) begin
          if ((seq_width_q == 3'd2 && acc < u8sv_pkg::MIN_W2) ||
              (seq_width_q == 3'd3 && acc < u8sv_pkg::MIN_W3) ||
              (seq_width_q == 3'd4 && acc < u8sv_pkg::MIN_W4)) begin
            err = u8sv_pkg::ERR_OVERLONG;
          end else if (acc >= u8sv_pkg::SURR_LO && acc <= u8sv_pkg::SURR_HI) begin
            err = u8sv_pkg::ERR_SURROGATE;
          end else if (acc > u8sv_pkg::MAX_CP) begin
            err = u8sv_pkg::ERR_RANGE;
          end else begin
            pv = 1'b1;
            cp = acc;
            pw = seq_width_q;
          end
          seq_width_d = 3'd0;
          partial_d   = '0;
        end
      end else begin
        err = u8sv_pkg::ERR_BAD_CONT;
      end

      // Buffer ends inside a sequence
      if (err == u8sv_pkg::ERR_NONE && item_i.last && bytes_left_d != 2'd0) begin
        err = u8sv_pkg::ERR_TRUNCATED;
      end

      if (err != u8sv_pkg::ERR_NONE) begin
        err_seen_d   = 1'b1;
        first_err_d  = err;
        bytes_left_d = 2'd0;
        seq_width_d  = 3'd0;
        partial_d    = '0;
      end
    end

    ok = item_i.last & ~err_seen_d;
  end

  // State registers, cleared after the last byte of a buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= 2'd0;
      seq_width_q  <= 3'd0;
      partial_q    <= '0;
      err_seen_q   <= 1'b0;
      first_err_q  <= u8sv_pkg::ERR_NONE;
    end else if (fire) begin
      if (item_i.last) begin
        bytes_left_q <= 2'd0;
        seq_width_q  <= 3'd0;
        partial_q    <= '0;
        err_seen_q   <= 1'b0;
        first_err_q  <= u8sv_pkg::ERR_NONE;
      end else begin
        bytes_left_q <= bytes_left_d;
        seq_width_q  <= seq_width_d;
        partial_q    <= partial_d;
        err_seen_q   <= err_seen_d;
        first_err_q  <= first_err_d;
      end
    end
  end

  // Output beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      pv_q   <= pv;
      cp_q   <= cp;
      pw_q   <= pw;
      end_q  <= item_i.last;
      ok_q   <= ok;
      kind_q <= first_err_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign point_valid_o = pv_q;
  assign code_point_o  = cp_q;
  assign point_width_o = pw_q;
  assign buffer_end_o  = end_q;
  assign buffer_ok_o   = ok_q;
  assign error_kind_o  = kind_q;

endmodule
